// ===== rtl/core/tlfp_pkg.sv =====
package tlfp_pkg;

  // Line layout
  localparam int unsigned NumFields = 5;
  localparam logic [7:0]  Separator = 8'h20;
  localparam logic [31:0] AzMax     = 32'd3600;

  // Field codes
  localparam logic [2:0] FLD_AZIMUTH  = 3'd0;
  localparam logic [2:0] FLD_ACCEL_X  = 3'd1;
  localparam logic [2:0] FLD_ACCEL_Y  = 3'd2;
  localparam logic [2:0] FLD_ACCEL_Z  = 3'd3;
  localparam logic [2:0] FLD_INTERVAL = 3'd4;

  // Status codes
  localparam logic [1:0] ST_STORED   = 2'd0;
  localparam logic [1:0] ST_AZ_RANGE = 2'd1;
  localparam logic [1:0] ST_NO_SEP   = 2'd2;

  // Result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  // Number scanner phase
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // One result record with a snapshot of the stored values
  typedef struct packed {
    logic [2:0]         field;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [11:0]        azimuth;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] interval;
    logic               last;
  } result_t;

endpackage

// ===== rtl/core/telemetry_line_field_parser_top.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  text_byte, line_end
// result    out        out_valid/out_ready  event_field .. last_of_run
//
// An accepted byte is held in the input register and, once the queue has room, is
// parsed into a four-entry result queue that offers its results in order.
// One byte per cycle is accepted while the queue has room; a byte that gives two
// results puts both in the queue, which offers one at a time on its single result port.
// Synchronous reset clears the field position, number scanner, stored values and
// the queue. The input stalls while the queue has fewer than two free entries.
module telemetry_line_field_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               line_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_field,
  output logic signed [31:0] parsed_value,
  output logic [1:0]         event_status,
  output logic [11:0]        azimuth_tenths,
  output logic signed [31:0] accel_x_milli,
  output logic signed [31:0] accel_y_milli,
  output logic signed [31:0] accel_z_milli,
  output logic signed [31:0] interval_ms,
  output logic               last_of_run
);
  import tlfp_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_end;
  logic       consume, room;
  result_t    rec0, rec1, out_rec;
  logic [1:0] rec_n, push_n;

  assign consume  = in_vld && room;
  assign in_ready = !in_vld || consume;
  assign push_n   = consume ? rec_n : 2'd0;

  // Hold the request in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= text_byte;
      in_end  <= line_end;
    end
  end

  tlfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (consume),
    .text_byte (in_byte),
    .line_end  (in_end),
    .rec0      (rec0),
    .rec1      (rec1),
    .rec_n     (rec_n)
  );

  tlfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_rec0 (rec0),
    .push_rec1 (rec1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  // Drive the result fields
  assign event_field    = out_rec.field;
  assign parsed_value   = out_rec.value;
  assign event_status   = out_rec.status;
  assign azimuth_tenths = out_rec.azimuth;
  assign accel_x_milli  = out_rec.accel_x;
  assign accel_y_milli  = out_rec.accel_y;
  assign accel_z_milli  = out_rec.accel_z;
  assign interval_ms    = out_rec.interval;
  assign last_of_run    = out_rec.last;

endmodule

// ===== rtl/core/tlfp_parse.sv =====
module tlfp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        text_byte,
  input  logic              line_end,
  output tlfp_pkg::result_t rec0,
  output tlfp_pkg::result_t rec1,
  output logic [1:0]        rec_n
);
  import tlfp_pkg::*;

  logic [2:0]  pos, pos_next;
  phase_t      phase, phase_next;
  logic        neg, neg_next;
  logic [31:0] mag, mag_next;
  logic [11:0] az, az_next;
  logic [31:0] ax, ax_next, ay, ay_next, az_acc, az_acc_next, ivl, ivl_next;

  logic        is_digit, is_ws, is_sign;
  logic [31:0] mag_sat, num_val;
  logic [35:0] prod;
  logic        sep_hit, miss;
  logic [1:0]  sep_status;
  logic [2:0]  miss_field;

  // Classify the byte
  assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_ws    = (text_byte >= 8'h09) && (text_byte <= 8'h0D);
  assign is_sign  = (text_byte == 8'h2B) || (text_byte == 8'h2D);

  // Signed value of the number so far, saturated to 32 bits
  assign mag_sat = (mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
  assign num_val = neg ? (32'd0 - mag_sat)
                       : ((mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag);

  // Multiply by ten and add the digit
  assign prod = ({4'd0, mag} << 3) + ({4'd0, mag} << 1)
              + {32'd0, text_byte[3:0]};

  always_comb begin
    pos_next    = pos;
    phase_next  = phase;
    neg_next    = neg;
    mag_next    = mag;
    az_next     = az;
    ax_next     = ax;
    ay_next     = ay;
    az_acc_next = az_acc;
    ivl_next    = ivl;
    sep_hit     = 1'b0;
    sep_status  = ST_STORED;
    miss        = 1'b0;

    if (pos < 3'(NumFields)) begin
      if (text_byte == Separator) begin
        // Close the field and store its value (azimuth only when in range)
        sep_hit = 1'b1;
        case (pos)
          FLD_AZIMUTH: begin
            if (!num_val[31] && (num_val <= AzMax)) begin
              az_next = num_val[11:0];
            end else begin
              sep_status = ST_AZ_RANGE;
            end
          end
          FLD_ACCEL_X: ax_next = num_val;
          FLD_ACCEL_Y: ay_next = num_val;
          FLD_ACCEL_Z: az_acc_next = num_val;
          default:     ivl_next = num_val;
        endcase
        pos_next   = pos + 3'd1;
        phase_next = PH_SKIP;
        neg_next   = 1'b0;
        mag_next   = '0;
      end else begin
        // Advance the number scanner
        case (phase)
          PH_DONE: ;
          default: begin
            if ((phase == PH_SKIP) && is_ws) begin
              phase_next = phase;
            end else if ((phase == PH_SKIP) && is_sign) begin
              neg_next   = (text_byte == 8'h2D);
              phase_next = PH_SIGN;
            end else if (is_digit) begin
              mag_next   = (prod > 36'h0_8000_0000) ? 32'h8000_0000 : prod[31:0];
              phase_next = PH_DIGITS;
            end else begin
              phase_next = PH_DONE;
            end
          end
        endcase
      end
    end

    miss_field = pos_next;

    // Flag the field in progress at line end, then restart
    if (line_end) begin
      miss       = (pos_next < 3'(NumFields));
      pos_next   = '0;
      phase_next = PH_SKIP;
      neg_next   = 1'b0;
      mag_next   = '0;
    end
  end

  // Build the result records
  always_comb begin
    result_t r_sep, r_miss;
    r_sep.field    = pos;
    r_sep.value    = num_val;
    r_sep.status   = sep_status;
    r_sep.azimuth  = az_next;
    r_sep.accel_x  = ax_next;
    r_sep.accel_y  = ay_next;
    r_sep.accel_z  = az_acc_next;
    r_sep.interval = ivl_next;
    r_sep.last     = !miss;
    r_miss         = r_sep;
    r_miss.field   = miss_field;
    r_miss.value   = '0;
    r_miss.status  = ST_NO_SEP;
    r_miss.last    = 1'b1;
    rec0  = sep_hit ? r_sep : r_miss;
    rec1  = r_miss;
    rec_n = {1'b0, sep_hit} + {1'b0, miss};
  end

  // Update the state on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      phase  <= PH_SKIP;
      neg    <= 1'b0;
      mag    <= '0;
      az     <= '0;
      ax     <= '0;
      ay     <= '0;
      az_acc <= '0;
      ivl    <= '0;
    end else if (take) begin
      pos    <= pos_next;
      phase  <= phase_next;
      neg    <= neg_next;
      mag    <= mag_next;
      az     <= az_next;
      ax     <= ax_next;
      ay     <= ay_next;
      az_acc <= az_acc_next;
      ivl    <= ivl_next;
    end
  end

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (take && line_end) |=> (pos == '0))
    else $error("field position not cleared after line end");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= 3'(NumFields))
    else $error("field position past last field");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (rec_n == 2'd2) |-> (!rec0.last && (rec0.status != ST_NO_SEP) && rec1.last))
    else $error("two results in wrong order");

endmodule

// ===== rtl/core/tlfp_queue.sv =====
module tlfp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  tlfp_pkg::result_t push_rec0,
  input  tlfp_pkg::result_t push_rec1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tlfp_pkg::result_t out_rec
);
  import tlfp_pkg::*;

  result_t            mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr, rd_ptr;
  logic [QPtrW:0]     count, count_next;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_rec   = mem[rd_ptr];
  assign room      = (count <= (QPtrW+1)'(QDepth - 2));
  assign count_next = count + (QPtrW+1)'(push_n) - (QPtrW+1)'(pop);

  // Write incoming records
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_rec0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + QPtrW'(1)] <= push_rec1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push_n);
      rd_ptr <= rd_ptr + QPtrW'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPtrW+1)'(QDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> room)
    else $error("push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && (push_n == 2'd0)) |=> (count == $past(count) - 1'b1))
    else $error("fill count wrong after pop");

endmodule

// ===== dv/tb_telemetry_line_field_parser_top.sv =====
`timescale 1ns / 1ps

module tb_telemetry_line_field_parser_top;
  import tlfp_pkg::*;

  // Characters the line scanner treats specially, and the lowest and highest byte values
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TOP   = 8'hFF;

  localparam int unsigned BytesPerPhase = 275;
  localparam int unsigned ShownMismatches = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         text_byte = 8'h00;
  logic               line_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         event_field;
  logic signed [31:0] parsed_value;
  logic [1:0]         event_status;
  logic [11:0]        azimuth_tenths;
  logic signed [31:0] accel_x_milli;
  logic signed [31:0] accel_y_milli;
  logic signed [31:0] accel_z_milli;
  logic signed [31:0] interval_ms;
  logic               last_of_run;

  // Flow-control knobs, percent of cycles
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // Shadow parser state
  logic [2:0]         field_idx;
  phase_t             scan_phase;
  logic               scan_negative;
  logic [31:0]        scan_magnitude;
  logic [11:0]        azimuth_held;
  logic signed [31:0] accel_held [3];
  logic signed [31:0] interval_held;

  result_t     expected_reports [$];
  logic [7:0]  line_bytes [$];

  int unsigned bytes_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned missing_sep_seen = 0;
  int unsigned azimuth_rejects = 0;
  int unsigned mismatches = 0;

  telemetry_line_field_parser_top i_dut (.*);

  always #6 clk = ~clk;

  // Throttle the result side
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Line parser prediction
  // ---------------------------------------------------------------------------

  function void clear_scan();
    scan_phase = PH_SKIP;
    scan_negative = 1'b0;
    scan_magnitude = 32'd0;
  endfunction

  // Saturate the accumulated magnitude into the signed 32-bit range
  function logic [31:0] scan_result();
    logic [31:0] mag;
    mag = scan_magnitude;
    if (scan_negative) begin
      if (mag > 32'h8000_0000) mag = 32'h8000_0000;
      return 32'd0 - mag;
    end
    if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
    return mag;
  endfunction

  // Advance the number scanner by one non-separator character
  function void scan_char(logic [7:0] c);
    logic [63:0] grown;
    if (scan_phase == PH_DONE) return;
    if (scan_phase == PH_SKIP) begin
      if (c >= CH_TAB && c <= CH_CR) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        scan_negative = (c == CH_MINUS);
        scan_phase = PH_SIGN;
        return;
      end
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      grown = 64'(scan_magnitude) * 64'd10 + 64'(c) - 64'(CH_ZERO);
      if (grown > 64'h8000_0000) grown = 64'h8000_0000;
      scan_magnitude = grown[31:0];
      scan_phase = PH_DIGITS;
    end else begin
      scan_phase = PH_DONE;
    end
  endfunction

  function void queue_report(logic [2:0] fld, logic [31:0] val, logic [1:0] st, logic fin);
    result_t r;
    r.field    = fld;
    r.value    = val;
    r.status   = st;
    r.azimuth  = azimuth_held;
    r.accel_x  = accel_held[0];
    r.accel_y  = accel_held[1];
    r.accel_z  = accel_held[2];
    r.interval = interval_held;
    r.last     = fin;
    expected_reports.push_back(r);
  endfunction

  function void parse_text_byte(logic [7:0] c, logic eol);
    logic [31:0] val;
    logic [1:0]  st;
    logic        flag_follows;
    if (field_idx < NumFields) begin
      if (c == Separator) begin
        val = scan_result();
        st = ST_STORED;
        if (field_idx == FLD_AZIMUTH) begin
          if (!val[31] && val <= AzMax) azimuth_held = val[11:0];
          else st = ST_AZ_RANGE;
        end else if (field_idx == FLD_INTERVAL) begin
          interval_held = val;
        end else begin
          accel_held[int'(field_idx) - 1] = val;
        end
        flag_follows = eol && (int'(field_idx) + 1 < NumFields);
        queue_report(field_idx, val, st, !flag_follows);
        field_idx = field_idx + 3'd1;
        clear_scan();
      end else begin
        scan_char(c);
      end
    end
    if (eol) begin
      if (field_idx < NumFields) queue_report(field_idx, 32'd0, ST_NO_SEP, 1'b1);
      field_idx = FLD_AZIMUTH;
      clear_scan();
    end
  endfunction

  // Compare one delivered result with the oldest expectation
  function void compare_field_report();
    result_t got;
    result_t want;
    got.field    = event_field;
    got.value    = parsed_value;
    got.status   = event_status;
    got.azimuth  = azimuth_tenths;
    got.accel_x  = accel_x_milli;
    got.accel_y  = accel_y_milli;
    got.accel_z  = accel_z_milli;
    got.interval = interval_ms;
    got.last     = last_of_run;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= ShownMismatches)
        $display("ERROR %0t: result with nothing pending (field %0d value %0d)",
                 $realtime, got.field, got.value);
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (want.status == ST_NO_SEP) missing_sep_seen++;
    if (want.status == ST_AZ_RANGE) azimuth_rejects++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ShownMismatches)
        $display({"ERROR %0t (got/exp): field %0d/%0d value %0d/%0d status %0d/%0d ",
                  "az %0d/%0d ax %0d/%0d ay %0d/%0d az_acc %0d/%0d iv %0d/%0d last %0b/%0b"},
                 $realtime, got.field, want.field, got.value, want.value,
                 got.status, want.status, got.azimuth, want.azimuth,
                 got.accel_x, want.accel_x, got.accel_y, want.accel_y,
                 got.accel_z, want.accel_z, got.interval, want.interval,
                 got.last, want.last);
    end
  endfunction

  // Predict on each accepted request, check each delivered result
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) parse_text_byte(text_byte, line_end);
      if (out_valid && out_ready) compare_field_report();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Drive one byte and hold it until the request is taken
  task automatic send_char(input logic [7:0] c, input logic eol);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= c;
    line_end  <= eol;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  // Send the buffered line, marking its last byte as the line end
  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++)
      send_char(line_bytes[i], i == line_bytes.size() - 1);
    line_bytes.delete();
  endtask

  function automatic string digit_run(int unsigned len);
    string s;
    s = "";
    for (int i = 0; i < len; i++) s = $sformatf("%s%0d", s, $urandom_range(9));
    return s;
  endfunction

  // Text of one field: mostly clean numbers, some padded, signed or trailed by junk
  function automatic string field_text(int unsigned fld);
    string       s;
    string       junk;
    int unsigned pick;
    junk = "x.#,e:";
    s = "";
    if ($urandom_range(99) < 8)
      repeat ($urandom_range(1, 2)) s = $sformatf("%s%c", s, $urandom_range(9, 13));
    pick = $urandom_range(99);
    if (pick < 15) s = {s, "-"};
    else if (pick < 22) s = {s, "+"};
    pick = $urandom_range(99);
    if (fld == FLD_AZIMUTH) begin
      if (pick < 75) s = $sformatf("%s%0d", s, $urandom_range(0, 3600));
      else if (pick < 95) s = {s, digit_run($urandom_range(1, 12))};
    end else begin
      if (pick < 55) s = $sformatf("%s%0d", s, $urandom_range(0, 20000));
      else if (pick < 85) s = $sformatf("%s%0d", s, $urandom());
      else if (pick < 95) s = {s, digit_run($urandom_range(10, 14))};
    end
    if ($urandom_range(99) < 8) s = $sformatf("%s%c", s, junk[$urandom_range(5)]);
    return s;
  endfunction

  task automatic test_directed_lines();
    // Extremes and overflow both ways, empty signed field, junk after digits
    push_text("3600 -2147483649 9999999999 + 12a4 z");
    send_line();
    // Azimuth above range, every skipped whitespace, line ends on a separator
    push_text("3601 ");
    for (int c = CH_TAB; c <= CH_CR; c++) line_bytes.push_back(8'(c));
    push_text("+7 ");
    send_line();
    // Negative azimuth rejected, next field flagged
    push_text("-1 ");
    send_line();
    // NUL ends a number, top byte value inside a field cut by the line end
    line_bytes.push_back(CH_NUL);
    line_bytes.push_back(Separator);
    line_bytes.push_back(CH_TOP);
    send_line();
    // Line of a single byte
    push_text("5");
    send_line();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned goal;
    int unsigned shape;
    int unsigned cut;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    goal = bytes_sent + BytesPerPhase;
    while (bytes_sent < goal) begin
      shape = $urandom_range(99);
      if (shape < 8) begin
        // Raw noise
        repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
      end else begin
        for (int f = 0; f < NumFields; f++) push_text({field_text(f), " "});
        if (shape < 20) begin
          // Trailing text after the last separator
          repeat ($urandom_range(1, 5)) line_bytes.push_back(8'($urandom_range(255)));
        end else if (shape < 36) begin
          // Line cut short
          cut = $urandom_range(1, line_bytes.size());
          while (line_bytes.size() > cut) void'(line_bytes.pop_back());
        end
      end
      send_line();
    end
  endtask

  initial begin
    field_idx = FLD_AZIMUTH;
    clear_scan();
    azimuth_held = 12'd0;
    accel_held[0] = 32'sd0;
    accel_held[1] = 32'sd0;
    accel_held[2] = 32'sd0;
    interval_held = 32'sd0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_lines();
    test_random_traffic(0, 0);
    test_random_traffic(45, 0);
    test_random_traffic(0, 45);
    test_random_traffic(18, 18);
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_reports.size() != 0) mismatches++;

    $display("Sent %0d text bytes in four flow-control phases; checked %0d field results",
             bytes_sent, reports_checked);
    $display("  including %0d missing separators and %0d rejected azimuths, %0d mismatches",
             missing_sep_seen, azimuth_rejects, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still pending", expected_reports.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== telemetry_line_field_parser_top.f =====
rtl/core/tlfp_pkg.sv
rtl/core/tlfp_parse.sv
rtl/core/tlfp_queue.sv
rtl/core/telemetry_line_field_parser_top.sv
dv/tb_telemetry_line_field_parser_top.sv
